>>> rtl/core/wls_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the weighted Laplacian stencil.
package wls_pkg;

	localparam int FLOW_W     = 16;
	localparam int WEIGHT_W   = 16;
	localparam int DIFF_W     = FLOW_W + 1;
	localparam int PROD_W     = DIFF_W + WEIGHT_W + 1;
	localparam int LAP_W      = 36;
	localparam int ROW_W      = 16;
	localparam int COLS_W     = 11;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 8'd1;

	localparam int RST_ROWS = 480;
	localparam int RST_COLS = 640;

	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = 3;
	localparam int OUT_CNT_W = 4;
	localparam int OCC_W     = 5;

	typedef struct packed {
		logic signed [FLOW_W-1:0] flow;
		logic [WEIGHT_W-1:0]      weight;
	} pix_t;

	typedef struct packed {
		logic                     last;
		logic                     has_right;
		logic                     has_left;
		logic                     has_down;
		logic                     has_up;
		logic signed [FLOW_W-1:0] fc;
		logic [WEIGHT_W-1:0]      wc;
		logic signed [FLOW_W-1:0] fl;
		logic [WEIGHT_W-1:0]      wl;
		logic signed [FLOW_W-1:0] fd;
	} stencil_s1_t;

	typedef struct packed {
		logic                    last;
		logic signed [LAP_W-1:0] value;
	} result_t;

endpackage

>>> rtl/core/wls_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered, read-first output.
module wls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

>>> rtl/core/wls_seq.sv
`timescale 1ns / 1ps
// Frame sequencer: configuration, counters, line buffer addressing and the first stage.
module wls_seq #(
	parameter int MAX_COLS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic                                mode,
	input  logic signed [wls_pkg::FLOW_W-1:0]   flow_value,
	input  logic [wls_pkg::WEIGHT_W-1:0]        weight_value,
	input  logic                                cfg_wr,
	input  logic [wls_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wls_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                above_we,
	output logic [$clog2(MAX_COLS)-1:0]         above_waddr,
	output wls_pkg::pix_t                       above_wdata,
	output logic                                above_re,
	output logic [$clog2(MAX_COLS)-1:0]         above_raddr,
	input  wls_pkg::pix_t                       above_rdata,
	output logic                                two_we,
	output logic [$clog2(MAX_COLS)-1:0]         two_waddr,
	output wls_pkg::pix_t                       two_wdata,
	output logic                                two_re,
	output logic [$clog2(MAX_COLS)-1:0]         two_raddr,
	output logic                                s1_valid,
	output wls_pkg::stencil_s1_t                s1_data
);

	localparam int CW = $clog2(MAX_COLS);
	localparam logic [CW-1:0] RST_COLS_LAST =
		CW'((wls_pkg::RST_COLS > MAX_COLS) ? MAX_COLS - 1 : wls_pkg::RST_COLS - 1);
	localparam logic [wls_pkg::ROW_W-1:0] RST_ROWS_LAST = wls_pkg::ROW_W'(wls_pkg::RST_ROWS - 1);

	logic [wls_pkg::ROW_W-1:0] rows_last_q;
	logic [CW-1:0]             cols_last_q;
	logic [wls_pkg::ROW_W-1:0] row_q;
	logic [CW-1:0]             col_q;
	logic                      drain_q;
	logic                      fwd_q;
	wls_pkg::pix_t             fwd_data_q;
	wls_pkg::pix_t             left_q;
	logic                      valid_s1;
	wls_pkg::stencil_s1_t      data_s1;

	logic [wls_pkg::COLS_W-1:0] cols_raw;
	logic [CW-1:0]              cols_last_new;
	logic [wls_pkg::ROW_W-1:0]  rows_last_new;
	logic                       act_pix;
	logic                       act_drn;
	logic                       act;
	logic                       last_col;
	logic [CW-1:0]              col_nxt;
	wls_pkg::pix_t              center;
	wls_pkg::pix_t              in_pix;

	assign cols_raw = cfg_data[wls_pkg::COLS_W-1:0];

	always_comb begin
		if (cols_raw == '0) begin
			cols_last_new = '0;
		end else if (32'(cols_raw) > MAX_COLS) begin
			cols_last_new = CW'(MAX_COLS - 1);
		end else begin
			cols_last_new = CW'(32'(cols_raw) - 32'd1);
		end
		if (cfg_data == '0) begin
			rows_last_new = '0;
		end else begin
			rows_last_new = cfg_data - 1'b1;
		end
	end

	assign act_pix  = accept && !mode && !drain_q;
	assign act_drn  = accept && mode && drain_q;
	assign act      = act_pix || act_drn;
	assign last_col = (col_q == cols_last_q);
	assign col_nxt  = last_col ? '0 : col_q + 1'b1;
	assign center   = fwd_q ? fwd_data_q : above_rdata;
	assign in_pix   = '{flow: flow_value, weight: weight_value};

	assign above_we    = act_pix;
	assign above_waddr = col_q;
	assign above_wdata = in_pix;
	assign above_re    = act;
	assign above_raddr = col_nxt;
	assign two_we      = act_pix;
	assign two_waddr   = col_q;
	assign two_wdata   = center;
	assign two_re      = act;
	assign two_raddr   = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_last_q <= RST_ROWS_LAST;
			cols_last_q <= RST_COLS_LAST;
			row_q       <= '0;
			col_q       <= '0;
			drain_q     <= 1'b0;
			fwd_q       <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= act && (act_drn || row_q != '0);
			if (act) begin
				fwd_q <= act_pix && (col_nxt == col_q);
			end
			if (cfg_wr) begin
				if (cfg_index == wls_pkg::REG_FRAME_ROWS) begin
					rows_last_q <= rows_last_new;
				end
				if (cfg_index == wls_pkg::REG_FRAME_COLS) begin
					cols_last_q <= cols_last_new;
				end
				if (cfg_index == wls_pkg::REG_FRAME_ROWS ||
				    cfg_index == wls_pkg::REG_FRAME_COLS) begin
					row_q   <= '0;
					col_q   <= '0;
					drain_q <= 1'b0;
				end
			end else if (act_pix) begin
				col_q <= col_nxt;
				if (last_col) begin
					if (row_q == rows_last_q) begin
						drain_q <= 1'b1;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
			end else if (act_drn) begin
				col_q <= col_nxt;
				if (last_col) begin
					row_q   <= '0;
					drain_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act) begin
			fwd_data_q        <= in_pix;
			left_q            <= center;
			data_s1.last      <= act_drn && last_col;
			data_s1.has_right <= !last_col;
			data_s1.has_left  <= (col_q != '0);
			data_s1.has_down  <= act_pix;
			data_s1.has_up    <= act_pix ? (row_q[wls_pkg::ROW_W-1:1] != '0)
			                             : (rows_last_q != '0);
			data_s1.fc        <= center.flow;
			data_s1.wc        <= center.weight;
			data_s1.fl        <= left_q.flow;
			data_s1.wl        <= left_q.weight;
			data_s1.fd        <= flow_value;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_data  = data_s1;

endmodule

>>> rtl/core/wls_arith.sv
`timescale 1ns / 1ps
// Stencil arithmetic: differences, four weighted products and their sum.
module wls_arith (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s1_valid,
	input  wls_pkg::stencil_s1_t                s1_data,
	input  logic signed [wls_pkg::FLOW_W-1:0]   right_flow,
	input  wls_pkg::pix_t                       up_pix,
	output logic                                res_valid,
	output wls_pkg::result_t                    res,
	output logic [1:0]                          inflight
);

	localparam int DW = wls_pkg::DIFF_W;
	localparam int WW = wls_pkg::WEIGHT_W;
	localparam int PW = wls_pkg::PROD_W;
	localparam int LW = wls_pkg::LAP_W;

	logic                 valid_s2;
	logic                 last_s2;
	logic [WW-1:0]        w_s2 [4];
	logic signed [DW-1:0] d_s2 [4];
	logic                 valid_s3;
	logic                 last_s3;
	logic signed [PW-1:0] p_s3 [4];

	logic signed [DW-1:0] d_r;
	logic signed [DW-1:0] d_l;
	logic signed [DW-1:0] d_d;
	logic signed [DW-1:0] d_u;

	function automatic logic signed [DW-1:0] sdiff(
		input logic signed [wls_pkg::FLOW_W-1:0] a,
		input logic signed [wls_pkg::FLOW_W-1:0] b
	);
		sdiff = DW'(a) - DW'(b);
	endfunction

	always_comb begin
		d_r = s1_data.has_right ? sdiff(s1_data.fc, right_flow) : '0;
		d_l = s1_data.has_left ? sdiff(s1_data.fc, s1_data.fl) : '0;
		d_d = s1_data.has_down ? sdiff(s1_data.fc, s1_data.fd) : '0;
		d_u = s1_data.has_up ? sdiff(s1_data.fc, up_pix.flow) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= s1_valid;
			valid_s3 <= valid_s2;
		end
	end

	// Out-of-frame differences and out-of-frame left and up weights are zeroed.
	always_ff @(posedge clk) begin
		last_s2 <= s1_data.last;
		w_s2[0] <= s1_data.wc;
		w_s2[1] <= s1_data.has_left ? s1_data.wl : '0;
		w_s2[2] <= s1_data.wc;
		w_s2[3] <= s1_data.has_up ? up_pix.weight : '0;
		d_s2[0] <= d_r;
		d_s2[1] <= d_l;
		d_s2[2] <= d_d;
		d_s2[3] <= d_u;
		last_s3 <= last_s2;
		for (int i = 0; i < 4; i++) begin
			p_s3[i] <= $signed({1'b0, w_s2[i]}) * d_s2[i];
		end
	end

	assign res_valid = valid_s3;
	assign res.last  = last_s3;
	assign res.value = LW'(p_s3[0]) + LW'(p_s3[1]) + LW'(p_s3[2]) + LW'(p_s3[3]);
	assign inflight  = 2'(valid_s2) + 2'(valid_s3);

endmodule

>>> rtl/core/wls_out_fifo.sv
`timescale 1ns / 1ps
// Output queue that holds finished result words until they are taken.
module wls_out_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  wls_pkg::result_t               wdata,
	input  logic                           pop,
	output logic                           rvalid,
	output wls_pkg::result_t               rdata,
	output logic [wls_pkg::OUT_CNT_W-1:0]  count
);

	wls_pkg::result_t                mem_q [wls_pkg::OUT_DEPTH];
	logic [wls_pkg::OUT_PTR_W-1:0]   wptr_q;
	logic [wls_pkg::OUT_PTR_W-1:0]   rptr_q;
	logic [wls_pkg::OUT_CNT_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + wls_pkg::OUT_CNT_W'(push) - wls_pkg::OUT_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	assign rvalid = (count_q != '0);
	assign rdata  = mem_q[rptr_q];
	assign count  = count_q;

endmodule

>>> rtl/core/weighted_laplacian_stencil.sv
`timescale 1ns / 1ps
// Top level of the weighted Laplacian five-point stencil.
// The block takes one word per clock cycle, pixel or drain, while in_ready is high, and returns
// results at the same sustained rate of one per cycle while out_ready is high. The results of
// row r are released by the pixels of row r+1, and the last row by one drain word per column.
// The rows above the incoming pixel sit in two line buffer RAMs of MAX_COLS entries, each read
// once per word and written once per pixel word, so the rate is set by one access per word on
// each RAM port. Input ready is withheld only when the eight-word output queue, together with
// the up to three results still in the stages, is full. No clearing pass runs after reset. A
// configuration write to the frame row or column register restarts the frame.
module weighted_laplacian_stencil #(
	parameter int MAX_COLS = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  mode,
	input  logic signed [wls_pkg::FLOW_W-1:0]     flow_value,
	input  logic [wls_pkg::WEIGHT_W-1:0]          weight_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [wls_pkg::LAP_W-1:0]      lap_value,
	output logic                                  last_of_frame,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [wls_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wls_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int PW = $bits(wls_pkg::pix_t);

	logic                            above_we;
	logic [CW-1:0]                   above_waddr;
	wls_pkg::pix_t                   above_wdata;
	logic                            above_re;
	logic [CW-1:0]                   above_raddr;
	wls_pkg::pix_t                   above_rdata;
	logic                            two_we;
	logic [CW-1:0]                   two_waddr;
	wls_pkg::pix_t                   two_wdata;
	logic                            two_re;
	logic [CW-1:0]                   two_raddr;
	wls_pkg::pix_t                   two_rdata;
	logic                            s1_valid;
	wls_pkg::stencil_s1_t            s1_data;
	logic                            res_valid;
	wls_pkg::result_t                res;
	logic [1:0]                      inflight;
	wls_pkg::result_t                head;
	logic [wls_pkg::OUT_CNT_W-1:0]   fifo_count;
	logic [wls_pkg::OCC_W-1:0]       occupancy;

	assign cfg_ready = 1'b1;
	assign occupancy = wls_pkg::OCC_W'(fifo_count) + wls_pkg::OCC_W'(s1_valid)
	                 + wls_pkg::OCC_W'(inflight);
	assign in_ready  = (occupancy < wls_pkg::OCC_W'(wls_pkg::OUT_DEPTH));

	wls_seq #(
		.MAX_COLS(MAX_COLS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_valid && in_ready),
		.mode        (mode),
		.flow_value  (flow_value),
		.weight_value(weight_value),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.above_we    (above_we),
		.above_waddr (above_waddr),
		.above_wdata (above_wdata),
		.above_re    (above_re),
		.above_raddr (above_raddr),
		.above_rdata (above_rdata),
		.two_we      (two_we),
		.two_waddr   (two_waddr),
		.two_wdata   (two_wdata),
		.two_re      (two_re),
		.two_raddr   (two_raddr),
		.s1_valid    (s1_valid),
		.s1_data     (s1_data)
	);

	wls_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_COLS)
	) u_line_above (
		.clk  (clk),
		.we   (above_we),
		.waddr(above_waddr),
		.wdata(above_wdata),
		.re   (above_re),
		.raddr(above_raddr),
		.rdata(above_rdata)
	);

	wls_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_COLS)
	) u_line_two_above (
		.clk  (clk),
		.we   (two_we),
		.waddr(two_waddr),
		.wdata(two_wdata),
		.re   (two_re),
		.raddr(two_raddr),
		.rdata(two_rdata)
	);

	wls_arith u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1_data   (s1_data),
		.right_flow(above_rdata.flow),
		.up_pix    (two_rdata),
		.res_valid (res_valid),
		.res       (res),
		.inflight  (inflight)
	);

	wls_out_fifo u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_valid),
		.wdata (res),
		.pop   (out_valid && out_ready),
		.rvalid(out_valid),
		.rdata (head),
		.count (fifo_count)
	);

	assign lap_value     = head.value;
	assign last_of_frame = head.last;

endmodule

>>> rtl/core/wls_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the stencil top level and their binding.
module wls_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [wls_pkg::LAP_W-1:0] lap_value,
	input logic                             last_of_frame
);

	// A stalled result word stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(lap_value) && $stable(last_of_frame))
		else $error("result word changed while stalled");

	// An empty output is refilled only by an accepted word that has passed the first stage and the arithmetic stages.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 4))
		else $error("result appeared without a releasing input word");

	// With the queue empty and nothing in flight, the input must be ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(in_valid && in_ready, 1) && !$past(in_valid && in_ready, 2)
		&& !$past(in_valid && in_ready, 3) |-> in_ready)
		else $error("input stalled while the block is empty");

endmodule

bind weighted_laplacian_stencil wls_checker u_wls_checker (.*);
